// ----- hdl/nfa_string_matcher_macros.svh -----
// Assertion macros shared by the nfa_string_matcher RTL.
// No dependencies; included by the files that carry assertions.
`ifndef NFA_STRING_MATCHER_MACROS_SVH
`define NFA_STRING_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/nsm_pkg.sv -----
// Shared types and constants of the NFA string matcher.
// No dependencies; used by nsm_ctrl, nsm_datapath and nfa_string_matcher.
package nsm_pkg;

    localparam int STATES_DEF  = 16;
    localparam int SYMBOLS_DEF = 4;
    localparam int ALPHA_MAX   = 4;

    localparam int S_DATA_W    = 32;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 3;

    localparam logic [S_USER_W-1:0] KIND_TRANS  = 3'd0;
    localparam logic [S_USER_W-1:0] KIND_EPS    = 3'd1;
    localparam logic [S_USER_W-1:0] KIND_ACCEPT = 3'd2;
    localparam logic [S_USER_W-1:0] KIND_CHAR   = 3'd3;
    localparam logic [S_USER_W-1:0] KIND_EOS    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_CHARS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd1;

    typedef struct packed {
        logic accept;
        logic clear_set;
        logic close_step;
        logic move_issue;
        logic move_commit;
        logic fin_load;
    } nsm_cmd_t;

    typedef struct packed {
        logic is_char;
        logic is_eos;
        logic sym_hit;
        logic closed;
        logic move_last;
        logic out_busy;
    } nsm_status_t;

endpackage

// ----- hdl/nsm_ctrl.sv -----
// Controller FSM of the NFA string matcher: input handshake and sequencing.
// Depends on nsm_pkg; drives nsm_datapath through nsm_cmd_t.
module nsm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  nsm_pkg::nsm_status_t status,
    output nsm_pkg::nsm_cmd_t    cmd
);
    import nsm_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_CLOSE = 5'b00010,
        ST_MOVE  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   op_char_reg;
    logic   op_char_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        op_char_next = op_char_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_char)
                    begin
                        if (status.sym_hit)
                        begin
                            state_next   = ST_CLOSE;
                            op_char_next = 1'b1;
                        end
                        else
                        begin
                            cmd.clear_set = 1'b1;
                        end
                    end
                    else if (status.is_eos)
                    begin
                        state_next   = ST_CLOSE;
                        op_char_next = 1'b0;
                    end
                end
            end
            ST_CLOSE:
            begin
                cmd.close_step = 1'b1;
                if (status.closed)
                begin
                    state_next = op_char_reg ? ST_MOVE : ST_FIN;
                end
            end
            ST_MOVE:
            begin
                cmd.move_issue = 1'b1;
                if (status.move_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.move_commit = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.fin_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_char_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_char_reg <= op_char_next;
        end
    end

endmodule

// ----- hdl/nsm_datapath.sv -----
// Datapath of the NFA string matcher: set registers, epsilon rows, symbol row
// memory, closure unit, symbol lookup and result register. Depends on nsm_pkg.
`include "nfa_string_matcher_macros.svh"
module nsm_datapath
#(
    parameter int STATES  = nsm_pkg::STATES_DEF,
    parameter int SYMBOLS = nsm_pkg::SYMBOLS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [nsm_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic [nsm_pkg::S_USER_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nsm_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                cfg_valid,
    input  logic [nsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  nsm_pkg::nsm_cmd_t                   cmd,
    output nsm_pkg::nsm_status_t                status
);
    import nsm_pkg::*;

    localparam int SW        = $clog2(STATES);
    localparam int YW        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int ADDR_W    = SW + YW;
    localparam int DEPTH     = 2 ** ADDR_W;
    localparam int ALPHA_USE = (SYMBOLS < ALPHA_MAX) ? SYMBOLS : ALPHA_MAX;

    logic [S_USER_W-1:0]   kind;
    logic [3:0]            row_state;
    logic [1:0]            row_symbol;
    logic [15:0]           row_targets;
    logic [CHAR_W-1:0]     character;
    logic [STATES-1:0]     targets;

    logic [STATES-1:0]     active_reg;
    logic [STATES-1:0]     work_reg;
    logic [STATES-1:0]     acc_reg;
    logic [STATES-1:0]     acc_next;
    logic [STATES-1:0]     grown;
    logic [STATES-1:0]     accept_mask_reg;
    logic [STATES-1:0]     eps_rows_reg [STATES];
    logic [STATES-1:0]     sym_mem [DEPTH];
    logic [STATES-1:0]     rd_data_reg;
    logic [31:0]           symbol_chars_reg;
    logic [COUNT_W-1:0]    symbol_count_reg;
    logic [COUNT_W-1:0]    used;
    logic [YW-1:0]         sym_idx_reg;
    logic [YW-1:0]         lookup_idx;
    logic                  lookup_hit;
    logic [SW-1:0]         cnt_reg;
    logic [SW-1:0]         rd_state_reg;
    logic                  rd_vld_reg;
    logic                  out_valid_reg;
    logic                  out_accepted_reg;
    logic                  trans_wr;
    logic                  eps_wr;

    assign kind        = s_tuser;
    assign row_state   = s_tdata[3:0];
    assign row_symbol  = s_tdata[5:4];
    assign row_targets = s_tdata[21:6];
    assign character   = s_tdata[29:22];
    assign targets     = STATES'(row_targets);

    assign trans_wr = cmd.accept && (kind == KIND_TRANS) &&
                      (int'(row_state) < STATES) && (int'(row_symbol) < SYMBOLS);
    assign eps_wr   = cmd.accept && (kind == KIND_EPS) && (int'(row_state) < STATES);

    // alphabet lookup, lowest matching symbol wins
    always_comb
    begin
        if (symbol_count_reg > COUNT_W'(ALPHA_USE))
            used = COUNT_W'(ALPHA_USE);
        else
            used = symbol_count_reg;
        lookup_hit = 1'b0;
        lookup_idx = '0;
        for (int j = ALPHA_USE - 1; j >= 0; j--)
        begin
            if ((COUNT_W'(j) < used) && (symbol_chars_reg[8*j +: 8] == character))
            begin
                lookup_hit = 1'b1;
                lookup_idx = YW'(j);
            end
        end
    end

    // one epsilon pass over all rows
    always_comb
    begin
        grown = work_reg;
        for (int s = 0; s < STATES; s++)
        begin
            if (work_reg[s])
                grown = grown | eps_rows_reg[s];
        end
    end

    assign acc_next = acc_reg |
                      ((rd_vld_reg && work_reg[rd_state_reg]) ? rd_data_reg : '0);

    assign status.is_char   = (kind == KIND_CHAR);
    assign status.is_eos    = (kind == KIND_EOS);
    assign status.sym_hit   = lookup_hit;
    assign status.closed    = (grown == work_reg);
    assign status.move_last = (cnt_reg == SW'(STATES - 1));
    assign status.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, out_accepted_reg};

    always_ff @(posedge clk)
    begin
        if (trans_wr)
            sym_mem[{SW'(row_state), YW'(row_symbol)}] <= targets;
        rd_data_reg <= sym_mem[{cnt_reg, sym_idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (eps_wr)
            eps_rows_reg[SW'(row_state)] <= targets;
        if (cmd.accept && (kind == KIND_ACCEPT))
            accept_mask_reg <= targets;
        if (cmd.accept)
        begin
            work_reg    <= active_reg;
            acc_reg     <= '0;
            sym_idx_reg <= lookup_idx;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.close_step)
                work_reg <= grown;
        end
        rd_state_reg <= cnt_reg;
        if (cmd.fin_load)
            out_accepted_reg <= |(work_reg & accept_mask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= STATES'(1);
            symbol_chars_reg <= '0;
            symbol_count_reg <= '0;
            cnt_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SYMBOL_CHARS: symbol_chars_reg <= cfg_data;
                    REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clear_set)
                active_reg <= '0;
            else if (cmd.move_commit)
                active_reg <= acc_next;
            else if (cmd.fin_load)
                active_reg <= STATES'(1);
            if (cmd.accept)
                cnt_reg <= '0;
            else if (cmd.move_issue)
                cnt_reg <= cnt_reg + SW'(1);
            rd_vld_reg <= cmd.move_issue;
            if (cmd.fin_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    `NSM_ASSERT_NEXT(a_close_grows, clk, rst_n, cmd.close_step, (work_reg & $past(work_reg)) == $past(work_reg))
    `NSM_ASSERT_IMPLY(a_commit_last_read, clk, rst_n, cmd.move_commit, rd_vld_reg)
    `NSM_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.fin_load, !(out_valid_reg && !m_tready))
    `NSM_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.fin_load, m_tvalid)

endmodule

// ----- hdl/nfa_string_matcher.sv -----
// Sequence: a character runs P <= STATES-1 epsilon passes (one per cycle) and a pass
// that finds the set closed; the move walks the symbol row memory one state per cycle
// and a drain step commits it. End of string closes the set and then loads the result.
// Throughput: one word at a time; a waiting result does not block loads.
// Reset: active set = state 0, alphabet registers zero; row stores are not cleared.
// Top level of the NFA string matcher; depends on nsm_pkg, nsm_ctrl, nsm_datapath.
module nfa_string_matcher
#(
    parameter int STATES  = nsm_pkg::STATES_DEF,
    parameter int SYMBOLS = nsm_pkg::SYMBOLS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_state[3:0], row_symbol[5:4], row_targets[21:6], character[29:22]
    input  logic [nsm_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [nsm_pkg::S_USER_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted[0]
    output logic [nsm_pkg::M_DATA_W-1:0]    m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nsm_pkg::*;

    nsm_cmd_t    cmd;
    nsm_status_t status;

    assign cfg_ready = 1'b1;

    nsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsm_datapath
    #(
        .STATES  (STATES),
        .SYMBOLS (SYMBOLS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- bench/nfa_string_matcher_test.sv -----
`timescale 1ns / 100ps
// Self-checking stream bench for nfa_string_matcher: loads rows, feeds strings, and
// compares each accept flag with a behavioral matcher kept alongside, or a planned value.
// Depends on nsm_pkg and the nfa_string_matcher RTL.
module nfa_string_matcher_test;
    import nsm_pkg::*;

    localparam logic [S_USER_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [S_USER_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [S_USER_W-1:0] KIND_SPARE_7 = 3'd7;
    localparam int NSTATE        = STATES_DEF;
    localparam int NSYM          = SYMBOLS_DEF;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int NDIR          = 25;

    typedef struct packed {
        logic [S_USER_W-1:0] kind;
        logic [3:0]          st;
        logic [1:0]          sym;
        logic [15:0]         tgt;
        logic [7:0]          ch;
        logic                typed;
        logic                want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic [S_USER_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // matcher state
    logic [15:0] trans_rows [0:NSTATE*NSYM-1];
    logic [15:0] eps_rows [0:NSTATE-1];
    logic [15:0] final_mask;
    logic [15:0] live_set;
    logic [31:0] alpha_chars;
    logic [2:0]  alpha_count;

    bit accept_q [$];
    int errors = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;

    dir_row_t plan [NDIR] = '{
        '{KIND_ACCEPT,  4'h0, 2'd0, 16'h0001, 8'h00, 1'b0, 1'b0},
        '{KIND_EOS,     4'hF, 2'd3, 16'hFFFF, 8'hFF, 1'b1, 1'b1},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'h7A, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b1, 1'b0},
        '{KIND_ACCEPT,  4'h9, 2'd2, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b1, 1'b0},
        '{KIND_TRANS,   4'h0, 2'd0, 16'h8000, 8'h55, 1'b0, 1'b0},
        '{KIND_TRANS,   4'hF, 2'd3, 16'hFFFF, 8'hAA, 1'b0, 1'b0},
        '{KIND_EPS,     4'h0, 2'd1, 16'h0001, 8'h00, 1'b0, 1'b0},
        '{KIND_ACCEPT,  4'h0, 2'd0, 16'hFFFF, 8'h00, 1'b0, 1'b0},
        '{KIND_CHAR,    4'hF, 2'd3, 16'hFFFF, 8'h61, 1'b0, 1'b0},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'h64, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b1, 1'b1},
        '{KIND_SPARE_5, 4'hF, 2'd3, 16'hFFFF, 8'hFF, 1'b0, 1'b0},
        '{KIND_SPARE_6, 4'h0, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{KIND_SPARE_7, 4'h5, 2'd1, 16'h5A5A, 8'h62, 1'b0, 1'b0},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'hFF, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b1, 1'b0},
        '{KIND_EPS,     4'hF, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{KIND_EPS,     4'h0, 2'd0, 16'h8001, 8'h00, 1'b0, 1'b0},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'h62, 1'b0, 1'b0},
        '{KIND_CHAR,    4'h0, 2'd0, 16'h0000, 8'h63, 1'b0, 1'b0},
        '{KIND_EOS,     4'h0, 2'd0, 16'h0000, 8'h00, 1'b0, 1'b0}
    };

    nfa_string_matcher u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_accept(input logic got);
        bit want;
        if (accept_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result, accepted=%0b", got));
        end
        else
        begin
            want = accept_q.pop_front();
            if (got !== want)
                report_mismatch($sformatf("accepted=%0b, expected %0b", got, want));
        end
    endtask

    function automatic logic [15:0] eps_closure(input logic [15:0] seed);
        logic [15:0] cur;
        logic [15:0] grown;
        cur = seed;
        for (int pass = 0; pass < NSTATE; pass++)
        begin
            grown = cur;
            for (int s = 0; s < NSTATE; s++)
                if (cur[s])
                    grown = grown | eps_rows[s];
            if (grown == cur)
                break;
            cur = grown;
        end
        return cur;
    endfunction

    function automatic int symbol_of(input logic [7:0] ch);
        int used;
        used = (alpha_count > 3'd4) ? 4 : int'(alpha_count);
        for (int j = 0; j < used; j++)
            if (alpha_chars[8*j +: 8] == ch)
                return j;
        return -1;
    endfunction

    task automatic step_matcher(input logic [S_USER_W-1:0] kind, input logic [3:0] st,
                                input logic [1:0] sym, input logic [15:0] tgt,
                                input logic [7:0] ch, output bit has_res, output bit res);
        logic [15:0] cur;
        logic [15:0] nxt;
        int j;
        has_res = 1'b0;
        res = 1'b0;
        case (kind)
            KIND_TRANS:  trans_rows[int'(st) * NSYM + int'(sym)] = tgt;
            KIND_EPS:    eps_rows[st] = tgt;
            KIND_ACCEPT: final_mask = tgt;
            KIND_CHAR:
            begin
                j = symbol_of(ch);
                nxt = '0;
                if (j >= 0)
                begin
                    cur = eps_closure(live_set);
                    for (int s = 0; s < NSTATE; s++)
                        if (cur[s])
                            nxt = nxt | trans_rows[s * NSYM + j];
                end
                live_set = nxt;
            end
            KIND_EOS:
            begin
                has_res = 1'b1;
                res = |(eps_closure(live_set) & final_mask);
                live_set = 16'h0001;
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [S_USER_W-1:0] kind, input logic [3:0] st,
                             input logic [1:0] sym, input logic [15:0] tgt,
                             input logic [7:0] ch, input bit typed, input bit want);
        bit has_res;
        bit res;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, ch, tgt, sym, st};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        step_matcher(kind, st, sym, tgt, ch, has_res, res);
        if (has_res)
            accept_q.push_back(typed ? want : res);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (accept_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_alphabet(input logic [31:0] chars, input logic [2:0] count);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_SYMBOL_CHARS;
        cfg_data  <= chars;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_SYMBOL_COUNT;
        cfg_data  <= {29'd0, count};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        alpha_chars = chars;
        alpha_count = count;
    endtask

    // mostly one or two target bits so that sets neither die nor flood
    function automatic logic [15:0] sparse_targets();
        logic [15:0] t;
        case ($urandom_range(0, 9))
            0:       t = '0;
            1:       t = '1;
            2:       t = 16'($urandom);
            default: t = (16'h0001 << $urandom_range(0, 15))
                         | (16'($urandom_range(0, 1)) << $urandom_range(0, 15));
        endcase
        return t;
    endfunction

    function automatic logic [15:0] eps_targets();
        return ($urandom_range(0, 2) == 0) ? sparse_targets() : 16'h0000;
    endfunction

    function automatic logic [7:0] pick_char();
        int used;
        used = (alpha_count > 3'd4) ? 4 : int'(alpha_count);
        if (used > 0 && $urandom_range(0, 9) != 0)
            return alpha_chars[8 * $urandom_range(0, used - 1) +: 8];
        return 8'($urandom);
    endfunction

    task automatic fill_stores();
        for (int s = 0; s < NSTATE; s++)
        begin
            push_item(KIND_EPS, 4'(s), 2'($urandom), eps_targets(), 8'($urandom), 1'b0, 1'b0);
            for (int k = 0; k < NSYM; k++)
                push_item(KIND_TRANS, 4'(s), 2'(k), sparse_targets(), 8'($urandom),
                          1'b0, 1'b0);
        end
        push_item(KIND_ACCEPT, 4'($urandom), 2'($urandom), sparse_targets(), 8'($urandom),
                  1'b0, 1'b0);
    endtask

    // strings of random length ending in end-of-string, with row reloads and noise between
    task automatic run_strings(input int n);
        int done;
        int len;
        done = 0;
        while (done < n)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    push_item(KIND_TRANS, 4'($urandom), 2'($urandom), sparse_targets(),
                              8'($urandom), 1'b0, 1'b0);
                    done++;
                end
                1:
                begin
                    push_item(KIND_EPS, 4'($urandom), 2'($urandom), eps_targets(),
                              8'($urandom), 1'b0, 1'b0);
                    done++;
                end
                2:
                begin
                    push_item(KIND_ACCEPT, 4'($urandom), 2'($urandom), sparse_targets(),
                              8'($urandom), 1'b0, 1'b0);
                    done++;
                end
                3:
                begin
                    push_item(3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7)), 4'($urandom),
                              2'($urandom), 16'($urandom), 8'($urandom), 1'b0, 1'b0);
                end
                default:
                begin
                    len = $urandom_range(0, 8);
                    repeat (len)
                        push_item(KIND_CHAR, 4'($urandom), 2'($urandom), 16'($urandom),
                                  pick_char(), 1'b0, 1'b0);
                    push_item(KIND_EOS, 4'($urandom), 2'($urandom), 16'($urandom),
                              8'($urandom), 1'b0, 1'b0);
                    done += len + 1;
                end
            endcase
        end
    endtask

    initial
    begin : result_side
        int stall_left;
        int hold_left;
        logic go;
        stall_left = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_accept(m_axis_tdata[0]);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                go = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                go = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                go = 1'b0;
            end
            else
            begin
                go = 1'b1;
            end
            m_axis_tready <= go;
        end
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        live_set    = 16'h0001;
        alpha_chars = '0;
        alpha_count = '0;
        final_mask  = '0;
        for (int i = 0; i < NSTATE * NSYM; i++)
            trans_rows[i] = '0;
        for (int i = 0; i < NSTATE; i++)
            eps_rows[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_alphabet(32'h64636261, 3'd4);
        fill_stores();
        for (int i = 0; i < NDIR; i++)
            push_item(plan[i].kind, plan[i].st, plan[i].sym, plan[i].tgt, plan[i].ch,
                      plan[i].typed, plan[i].want);

        // long result stall while words keep coming
        hold_req = 1'b1;
        run_strings(300);

        set_alphabet(32'h00000000, 3'd0);
        run_strings(100);

        // all symbols share one character, count beyond the alphabet
        set_alphabet(32'hFFFFFFFF, 3'd7);
        run_strings(250);

        set_alphabet($urandom, 3'($urandom_range(1, 7)));
        run_strings(200);
        drain();
        run_strings(200);

        set_alphabet(32'h00414241, 3'd5);
        run_strings(300);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_alphabet($urandom, 3'd4);
        run_strings(350);

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
